// File: rtl/ccrt_pkg.sv
`default_nettype none
// ============================================================================
// ccrt_pkg: shared definitions for the character class run tagger
// Widths, default sizes, the sequencer state type and the result beat type.
// ============================================================================
package ccrt_pkg;

  localparam int NUM_CLASSES_DEF = 64;
  localparam int TABLE_DEPTH     = 128;
  localparam int TABLE_AW        = 7;
  localparam int MAX_CLASSES     = 64;
  localparam int ACTIVE_W        = 7;
  localparam int CLASS_W         = 6;
  localparam int COUNT_W         = 8;
  localparam int OFFSET_W        = 32;
  localparam int MASK_W          = 64;

  localparam logic [TABLE_AW-1:0] HIGH_BYTE_ENTRY = TABLE_AW'(TABLE_DEPTH - 1);

  // Data byte versus table entry write.
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_TABLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TBL   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  typedef struct packed {
    logic [CLASS_W-1:0]  class_index;
    logic [COUNT_W-1:0]  run_length;
    logic [OFFSET_W-1:0] end_offset;
    logic                last;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/ccrt_ram.sv
`default_nettype none
// ============================================================================
// ccrt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
module ccrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccrt_seq.sv
`default_nettype none
// ============================================================================
// ccrt_seq: run tagger sequencer
// Looks up the class mask, walks the run counters one class per cycle unless
// stalled, by read-modify-write, and merges ended runs into the output register.
// ============================================================================
module ccrt_seq #(
  parameter int NUM_CLASSES = ccrt_pkg::NUM_CLASSES_DEF,
  parameter int IW          = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [ccrt_pkg::ACTIVE_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              func,
  input  wire logic [7:0]                        data_byte,
  input  wire logic [ccrt_pkg::TABLE_AW-1:0]     table_index,
  input  wire logic [ccrt_pkg::MASK_W-1:0]       class_mask,
  // class table RAM
  output logic                                   tbl_we,
  output logic [ccrt_pkg::TABLE_AW-1:0]          tbl_waddr,
  output logic [NUM_CLASSES-1:0]                 tbl_wdata,
  output logic                                   tbl_re,
  output logic [ccrt_pkg::TABLE_AW-1:0]          tbl_raddr,
  input  wire logic [NUM_CLASSES-1:0]            tbl_rdata,
  // run counter RAM
  output logic                                   cnt_we,
  output logic [IW-1:0]                          cnt_waddr,
  output logic [ccrt_pkg::COUNT_W-1:0]           cnt_wdata,
  output logic                                   cnt_re,
  output logic [IW-1:0]                          cnt_raddr,
  input  wire logic [ccrt_pkg::COUNT_W-1:0]      cnt_rdata,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output ccrt_pkg::result_t                      out_beat
);

  ccrt_pkg::state_t state;
  logic [ccrt_pkg::ACTIVE_W-1:0] active_classes;
  logic [ccrt_pkg::ACTIVE_W-1:0] n_eff;
  logic [ccrt_pkg::ACTIVE_W-1:0] n_q;
  logic [NUM_CLASSES-1:0]        mask;
  logic [IW-1:0]                 idx;
  logic [ccrt_pkg::OFFSET_W-1:0] offset;
  logic [ccrt_pkg::TABLE_DEPTH-1:0] tbl_vld;
  logic [NUM_CLASSES-1:0]        cnt_vld;
  logic                          tv_q;
  logic                          cv_q;
  logic                          pend_v;
  ccrt_pkg::result_t             pend;

  logic                          accept;
  logic [ccrt_pkg::COUNT_W-1:0]  cur;
  logic                          hit;
  logic                          emit;
  logic                          is_last;
  logic                          out_free;
  logic                          scan_hold;
  logic                          push_mid;
  logic                          push_fin;
  logic                          drain_done;

  assign in_stall = (state != ccrt_pkg::S_IDLE);
  assign accept   = in_valid && (state == ccrt_pkg::S_IDLE);

  assign n_eff = (active_classes > ccrt_pkg::ACTIVE_W'(NUM_CLASSES)) ?
                 ccrt_pkg::ACTIVE_W'(NUM_CLASSES) : active_classes;

  assign tbl_we    = accept && (func == ccrt_pkg::FUNC_TABLE);
  assign tbl_waddr = table_index;
  assign tbl_wdata = class_mask[NUM_CLASSES-1:0];
  assign tbl_re    = accept && (func == ccrt_pkg::FUNC_DATA);
  assign tbl_raddr = data_byte[7] ? ccrt_pkg::HIGH_BYTE_ENTRY
                                  : data_byte[ccrt_pkg::TABLE_AW-1:0];

  // A counter never written since reset reads as zero.
  assign cur     = cv_q ? cnt_rdata : '0;
  assign hit     = mask[idx];
  assign emit    = !hit && (cur != '0);
  assign is_last = (ccrt_pkg::ACTIVE_W'(idx) == (n_q - ccrt_pkg::ACTIVE_W'(1)));

  assign out_free   = !out_valid || !out_stall;
  assign scan_hold  = (state == ccrt_pkg::S_SCAN) && emit && pend_v && !out_free;
  assign push_mid   = (state == ccrt_pkg::S_SCAN) && emit && pend_v && out_free;
  assign push_fin   = (state == ccrt_pkg::S_DRAIN) && pend_v && out_free;
  assign drain_done = (state == ccrt_pkg::S_DRAIN) && (!pend_v || out_free);

  assign cnt_we    = (state == ccrt_pkg::S_SCAN) && !scan_hold;
  assign cnt_waddr = idx;
  assign cnt_wdata = hit ? cur + ccrt_pkg::COUNT_W'(1) : '0;
  assign cnt_re    = ((state == ccrt_pkg::S_TBL) && (n_q != '0)) ||
                     ((state == ccrt_pkg::S_SCAN) && !scan_hold && !is_last);
  assign cnt_raddr = (state == ccrt_pkg::S_TBL) ? '0 : idx + IW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ccrt_pkg::S_IDLE;
      active_classes <= '0;
      offset         <= '0;
      tbl_vld        <= '0;
      cnt_vld        <= '0;
      pend_v         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_classes <= cfg_wdata;
      end
      if (tbl_we) begin
        tbl_vld[table_index] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_vld[idx] <= 1'b1;
      end

      if (push_mid || push_fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ccrt_pkg::S_IDLE: begin
          if (tbl_re) begin
            state <= ccrt_pkg::S_TBL;
          end
        end
        ccrt_pkg::S_TBL: begin
          if (n_q == '0) begin
            offset <= offset + ccrt_pkg::OFFSET_W'(1);
            state  <= ccrt_pkg::S_IDLE;
          end else begin
            state <= ccrt_pkg::S_SCAN;
          end
        end
        ccrt_pkg::S_SCAN: begin
          if (!scan_hold) begin
            if (emit) begin
              pend_v <= 1'b1;
            end
            if (is_last) begin
              state <= ccrt_pkg::S_DRAIN;
            end
          end
        end
        ccrt_pkg::S_DRAIN: begin
          if (drain_done) begin
            pend_v <= 1'b0;
            offset <= offset + ccrt_pkg::OFFSET_W'(1);
            state  <= ccrt_pkg::S_IDLE;
          end
        end
        default: begin
          state <= ccrt_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (tbl_re) begin
      tv_q <= tbl_vld[tbl_raddr];
      n_q  <= n_eff;
    end
    if (state == ccrt_pkg::S_TBL) begin
      mask <= tv_q ? tbl_rdata : '0;
      idx  <= '0;
    end else if ((state == ccrt_pkg::S_SCAN) && !scan_hold && !is_last) begin
      idx <= idx + IW'(1);
    end
    if (cnt_re) begin
      cv_q <= cnt_vld[cnt_raddr];
    end
    if ((state == ccrt_pkg::S_SCAN) && !scan_hold && emit) begin
      pend.class_index <= ccrt_pkg::CLASS_W'(idx);
      pend.run_length  <= cur;
      pend.end_offset  <= offset;
      pend.last        <= 1'b0;
    end
    // Only the beat handed over while draining is the final one of its byte.
    if (push_mid || push_fin) begin
      out_beat <= '{class_index: pend.class_index,
                    run_length:  pend.run_length,
                    end_offset:  pend.end_offset,
                    last:        pend.last | push_fin};
    end
  end

endmodule
`default_nettype wire

// File: rtl/char_class_run_tagger_top.sv
`default_nettype none
// ============================================================================
// char_class_run_tagger_top: character class run tagger
// Counts runs of bytes per character class and reports each run as it ends.
// ============================================================================
// A 128-entry class table (one mask bit per class) and a run counter RAM with
// one 8-bit counter per class hold the masks and run counts. A data byte is
// accepted while the table is read; the mask is then latched, the active
// classes are walked one class per cycle through the counter RAM's single
// read-modify-write slot, and the final result is handed over. The walk holds
// while a second ended run waits on a stalled output, and the handover waits
// for a free output. Each ended run leaves as one output beat carrying the
// class, the run length and the offset of the byte that ended it, lowest
// class first, with last set on the final beat of a byte. Reset clears
// per-entry valid bits in flip-flops, so no clearing pass is needed and the
// block is ready in the first cycle after reset. The user must see that the
// active class count is written through cfg_we and cfg_wdata only while the
// block is idle; the block does not enforce this. Values above NUM_CLASSES
// act as NUM_CLASSES. Runs still open are never flushed.
module char_class_run_tagger_top #(
  parameter int NUM_CLASSES = ccrt_pkg::NUM_CLASSES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ccrt_pkg::ACTIVE_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          func,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [ccrt_pkg::TABLE_AW-1:0] table_index,
  input  wire logic [ccrt_pkg::MASK_W-1:0]   class_mask,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ccrt_pkg::CLASS_W-1:0]       class_index,
  output logic [ccrt_pkg::COUNT_W-1:0]       run_length,
  output logic [ccrt_pkg::OFFSET_W-1:0]      end_offset,
  output logic                               last
);

  // Class counter address width; a single class still needs one address bit.
  localparam int IW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic                          tbl_we;
  logic [ccrt_pkg::TABLE_AW-1:0] tbl_waddr;
  logic [NUM_CLASSES-1:0]        tbl_wdata;
  logic                          tbl_re;
  logic [ccrt_pkg::TABLE_AW-1:0] tbl_raddr;
  logic [NUM_CLASSES-1:0]        tbl_rdata;
  logic                          cnt_we;
  logic [IW-1:0]                 cnt_waddr;
  logic [ccrt_pkg::COUNT_W-1:0]  cnt_wdata;
  logic                          cnt_re;
  logic [IW-1:0]                 cnt_raddr;
  logic [ccrt_pkg::COUNT_W-1:0]  cnt_rdata;
  ccrt_pkg::result_t             out_beat;

  // The class table only stores the mask bits of classes that exist.
  ccrt_ram #(
    .WIDTH (NUM_CLASSES),
    .DEPTH (ccrt_pkg::TABLE_DEPTH),
    .AW    (ccrt_pkg::TABLE_AW)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Run counters. The sequencer writes class i while it reads class i + 1, so
  // the two ports never touch the same entry in one cycle.
  ccrt_ram #(
    .WIDTH (ccrt_pkg::COUNT_W),
    .DEPTH (NUM_CLASSES),
    .AW    (IW)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  ccrt_seq #(
    .NUM_CLASSES (NUM_CLASSES),
    .IW          (IW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data_byte   (data_byte),
    .table_index (table_index),
    .class_mask  (class_mask),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .tbl_re      (tbl_re),
    .tbl_raddr   (tbl_raddr),
    .tbl_rdata   (tbl_rdata),
    .cnt_we      (cnt_we),
    .cnt_waddr   (cnt_waddr),
    .cnt_wdata   (cnt_wdata),
    .cnt_re      (cnt_re),
    .cnt_raddr   (cnt_raddr),
    .cnt_rdata   (cnt_rdata),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat)
  );

  // The output register lives in the sequencer; unpack it onto the ports.
  assign class_index = out_beat.class_index;
  assign run_length  = out_beat.run_length;
  assign end_offset  = out_beat.end_offset;
  assign last        = out_beat.last;

endmodule
`default_nettype wire

// File: dv/tb_char_class_run_tagger_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_class_run_tagger_top: self-checking bench for the class run tagger
// Feeds class table writes and text bytes with random gaps, stalls the result
// side at random, and checks every run-end beat against a predicted one.
// ----------------------------------------------------------------------------

// Mirrors the class table, the per-class run counters and the stream offset,
// and keeps the run ends still owed by the block in arrival order.
class run_tracker;
  logic [ccrt_pkg::MASK_W-1:0]   class_table [ccrt_pkg::TABLE_DEPTH];
  logic [ccrt_pkg::COUNT_W-1:0]  run_counts [ccrt_pkg::MAX_CLASSES];
  logic [ccrt_pkg::OFFSET_W-1:0] byte_offset;
  int unsigned                   used_classes;
  ccrt_pkg::result_t             expected_ends [$];
  int unsigned                   errors;

  function new();
    foreach (class_table[i]) class_table[i] = '0;
    foreach (run_counts[i]) run_counts[i] = '0;
    byte_offset  = '0;
    used_classes = 0;
    errors       = 0;
  endfunction

  function void set_active(logic [ccrt_pkg::ACTIVE_W-1:0] count);
    used_classes = (count > ccrt_pkg::NUM_CLASSES_DEF) ? ccrt_pkg::NUM_CLASSES_DEF : count;
  endfunction

  function void note_beat(logic f, logic [7:0] b, logic [ccrt_pkg::TABLE_AW-1:0] idx,
                          logic [ccrt_pkg::MASK_W-1:0] mask);
    logic [ccrt_pkg::MASK_W-1:0]   m;
    logic [ccrt_pkg::TABLE_AW-1:0] entry;
    ccrt_pkg::result_t             held;
    bit                            have_held;
    if (f == ccrt_pkg::FUNC_TABLE) begin
      class_table[idx] = mask;
      return;
    end
    entry     = b[7] ? ccrt_pkg::HIGH_BYTE_ENTRY : b[6:0];
    m         = class_table[entry];
    have_held = 1'b0;
    held      = '0;
    for (int i = 0; i < used_classes; i++) begin
      if (m[i]) begin
        run_counts[i] = run_counts[i] + 1'b1;
      end else if (run_counts[i] != '0) begin
        // Each ended run is held back one step so the final one can be marked.
        if (have_held) expected_ends.push_back(held);
        held.class_index = ccrt_pkg::CLASS_W'(i);
        held.run_length  = run_counts[i];
        held.end_offset  = byte_offset;
        held.last        = 1'b0;
        have_held        = 1'b1;
        run_counts[i]    = '0;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_ends.push_back(held);
    end
    byte_offset = byte_offset + 1'b1;
  endfunction

  task check_run_end(ccrt_pkg::result_t got);
    ccrt_pkg::result_t want;
    if (expected_ends.size() == 0) begin
      report_mismatch($sformatf("unexpected run end: class %0d length %0d offset %0d last %0b",
                                got.class_index, got.run_length, got.end_offset, got.last));
      return;
    end
    want = expected_ends.pop_front();
    if (got !== want)
      report_mismatch($sformatf(
        "run end got class %0d len %0d off %0d last %0b, want %0d %0d %0d %0b",
        got.class_index, got.run_length, got.end_offset, got.last,
        want.class_index, want.run_length, want.end_offset, want.last));
  endtask

  task report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    errors++;
  endtask
endclass

module tb_char_class_run_tagger_top;
  import ccrt_pkg::*;

  // A byte can end no run at all, so the settle waits this many quiet cycles,
  // more than a data byte keeps the block busy, before the block counts as idle.
  localparam int SETTLE_CYCLES = MAX_CLASSES + 16;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [ACTIVE_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [7:0]          data_byte;
  logic [TABLE_AW-1:0] table_index;
  logic [MASK_W-1:0]   class_mask;
  logic                out_valid;
  logic                out_stall;
  logic [CLASS_W-1:0]  class_index;
  logic [COUNT_W-1:0]  run_length;
  logic [OFFSET_W-1:0] end_offset;
  logic                last;

  run_tracker tracker;
  bit         no_gaps;

  char_class_run_tagger_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data_byte   (data_byte),
    .table_index (table_index),
    .class_mask  (class_mask),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .class_index (class_index),
    .run_length  (run_length),
    .end_offset  (end_offset),
    .last        (last)
  );

  always #1 clk = ~clk;

  // Mostly short pauses, a few long ones. Used for both the sender's gaps
  // and the result side's stalls.
  function automatic int unsigned random_pause(int unsigned long_max);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, long_max);
  endfunction

  // Masks come in several shapes so runs are both long and short: all classes,
  // none, sparse, dense and plain random.
  function automatic logic [MASK_W-1:0] random_mask();
    logic [MASK_W-1:0] a;
    logic [MASK_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return a & b;
      3: return a | b;
      default: return a;
    endcase
  endfunction

  // Presents one input beat and returns at the edge that accepts it. Valid
  // stays high on return, so back-to-back beats need no extra assignment; a
  // gap or a settle lowers it.
  task automatic send_beat(input logic f, input logic [7:0] b, input logic [TABLE_AW-1:0] idx,
                           input logic [MASK_W-1:0] mask);
    int unsigned gap;
    gap = no_gaps ? 0 : random_pause(60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    data_byte   <= b;
    table_index <= idx;
    class_mask  <= mask;
    do @(posedge clk); while (in_stall);
    tracker.note_beat(f, b, idx, mask);
  endtask

  // The fields a beat does not use carry random junk; the block must ignore it.
  task automatic send_data(input logic [7:0] b);
    send_beat(FUNC_DATA, b, TABLE_AW'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_write(input logic [TABLE_AW-1:0] idx, input logic [MASK_W-1:0] mask);
    send_beat(FUNC_TABLE, 8'($urandom), idx, mask);
  endtask

  // Stops sending until every owed run end has come back and the block has
  // had time to finish a byte that ends no run.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.expected_ends.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [ACTIVE_W-1:0] count);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_active(count);
  endtask

  // A random phase loads a small alphabet into the table and then sends mostly
  // runs of repeated characters from it, so counters climb well past one. The
  // rest is random bytes, table rewrites in the middle of the stream, and the
  // odd pause until the result side has drained.
  task automatic random_phase(input int unsigned budget);
    logic [TABLE_AW-1:0] alphabet [4];
    logic [7:0]          b;
    int unsigned         sent;
    int unsigned         reps;
    int unsigned         pick;
    sent = 0;
    foreach (alphabet[i]) begin
      // Entry 127 is always in the alphabet since every high byte lands there.
      alphabet[i] = (i == 0) ? HIGH_BYTE_ENTRY : TABLE_AW'($urandom_range(0, 126));
      send_write(alphabet[i], random_mask());
      sent++;
    end
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        b    = {1'b0, alphabet[$urandom_range(0, 3)]};
        reps = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        repeat (reps) begin
          if (b == 8'd127 && $urandom_range(0, 1) == 1)
            send_data(8'($urandom_range(128, 255)));
          else
            send_data(b);
          sent++;
        end
      end else if (pick < 88) begin
        send_data(8'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 97) begin
        if ($urandom_range(0, 1) == 1)
          send_write(alphabet[$urandom_range(0, 3)], random_mask());
        else
          send_write(TABLE_AW'($urandom_range(0, 127)), random_mask());
        sent++;
      end else begin
        settle();
      end
    end
  endtask

  // Result side: random stalls, mostly short, with quiet stretches where the
  // block can push out results back to back.
  initial begin : result_stall
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end
      hold = random_pause(60);
      out_stall <= (hold != 0);
      repeat ((hold == 0) ? $urandom_range(1, 6) : hold) @(posedge clk);
    end
  end

  // Every accepted result beat is checked against the oldest owed run end.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_run_end({class_index, run_length, end_offset, last});
  end

  initial begin : stimulus
    tracker     = new();
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    func        = FUNC_DATA;
    data_byte   = '0;
    table_index = '0;
    class_mask  = '0;
    no_gaps     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reset leaves no class active, so these bytes must end no
    // run, leave every counter alone and still move the offset on.
    send_write(HIGH_BYTE_ENTRY, '1);
    send_write(TABLE_AW'(0), '0);
    send_write(TABLE_AW'(8'h41), 64'h8000_0000_0000_0001);
    send_data(8'h41);
    send_data(8'hFF);
    send_data(8'h00);

    // A count above the class limit acts as the limit. High bytes open runs
    // in all 64 classes, and a byte with an empty mask closes all of them.
    write_active(7'd127);
    send_data(8'hFF);
    send_data(8'h80);
    send_data(8'h00);
    send_data(8'h41);
    send_data(8'h7F);
    send_data(8'h00);
    // A table write in the middle of the stream replaces the whole mask.
    send_write(HIGH_BYTE_ENTRY, 64'h5555_5555_5555_5555);
    send_data(8'hC3);
    send_data(8'h00);

    // With one class active, mask bit 63 must be ignored.
    write_active(7'd1);
    send_data(8'h41);
    send_data(8'h00);
    write_active(7'd64);
    send_data(8'h41);
    send_data(8'h41);
    send_data(8'h00);

    // Counter wrap: class 1 starts its run one byte early, so after 255 more
    // matching bytes its counter is back at zero and the miss that follows
    // ends nothing for it, while classes 0 and 2 end with the longest
    // reportable length.
    write_active(7'd3);
    send_write(TABLE_AW'(8'h78), 64'h7);
    send_write(TABLE_AW'(8'h20), 64'h2);
    send_data(8'h20);
    repeat (255) send_data(8'h78);
    send_data(8'h00);

    // Random part over several class counts, the full 64 included. One phase
    // runs without gaps on the input side.
    write_active(7'd64);
    random_phase(13);
    no_gaps = 1'b1;
    write_active(7'd5);
    random_phase(13);
    no_gaps = 1'b0;
    write_active(7'd40);
    random_phase(13);
    write_active(ACTIVE_W'($urandom_range(0, 127)));
    random_phase(13);

    settle();
    if (tracker.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Worst case per byte is a long input gap, the scan of all 64 classes and 64
  // results each behind a long stall; the limit allows several times that for
  // about 330 beats plus the drains.
  initial begin : watchdog
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
